[sv/tsa_pkg.sv]
// Shared widths, stage records and constants for the triangle solid angle pipeline.
`timescale 1ns / 1ps

package tsa_pkg;

    localparam int CW    = 32;
    localparam int NF    = 12;
    localparam int OW    = CW + 1;
    localparam int PW    = 2 * OW;
    localparam int SW    = PW;
    localparam int DOTW  = PW + 2;
    localparam int NW    = 101;
    localparam int LW    = 50;
    localparam int REMW  = LW + 1;
    localparam int RADW  = 2 * LW;
    localparam int LSH   = 32;
    localparam int NSH   = 48;
    localparam int DW    = 154;
    localparam int VW    = DW - 1;
    localparam int NORM  = 60;
    localparam int XW    = 64;
    localparam int ZW    = 34;
    localparam int CS    = 32;
    localparam int DEPTH = 16 + LW + CS;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    localparam logic [31:0] ATAN_TAB [CS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [2:0][SW-1:0]   s;
        logic [2:0][LW-1:0]   root;
        logic [2:0][REMW-1:0] rem;
        logic [2:0][DOTW-1:0] dot;
        logic [NW-1:0]        n;
    } t_sq;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [ZW-1:0] z;
        logic          zn;
        logic          zd;
    } t_cd;

endpackage

[sv/triangle_solid_angle.sv]
// Top level: fully pipelined solid angle of a triangle seen from a point.
//
// Usage: one transaction on the slave stream carries the three vertices and the
// observation point (twelve signed Q16.16 words). One transaction on the master
// stream returns the absolute solid angle as unsigned Q2.30, at most pi.
// Results leave in the order the items arrived.
// Throughput is one item per clock cycle; a new transaction is taken in every
// cycle while the output side keeps up.
// The pipeline is made of the 50 stage square root (one result bit per
// stage), the 32 stage arctangent (one rotation per stage) and the products and
// normalization stages around them.
// A synchronous active low reset empties the pipeline and the output buffer.
// When the receiver stalls, the result waits in the output register and one
// more result is caught in a skid register; only then does the whole pipeline
// hold, dropping tready, and nothing in flight is lost or repeated.
`timescale 1ns / 1ps

module triangle_solid_angle
    import tsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z (32 bits each)
    input  logic [NF*CW-1:0]  i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // solid_angle (32 bits)
    output logic [31:0]       o_m_axis_tdata
);

    logic             en;
    logic [DEPTH-1:0] r_vld;
    logic             r_ov;
    logic [31:0]      r_od;
    logic             r_sk_v;
    logic [31:0]      r_sk_d;
    logic [31:0]      n_res;

    assign en = !r_sk_v;
    assign o_s_axis_tready = en && i_rst_n;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // Offsets from the observation point.
    logic signed [OW-1:0] r_s1_d [3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    r_s1_d[v][k] <= OW'($signed(i_s_axis_tdata[(v*3+k)*CW +: CW]))
                                  - OW'($signed(i_s_axis_tdata[(9+k)*CW +: CW]));
                end
            end
        end
    end

    // Products of offset components.
    logic signed [PW-1:0] r_s2_pc [6];
    logic signed [PW-1:0] r_s2_sq [3][3];
    logic signed [PW-1:0] r_s2_pr [3][3];
    logic signed [OW-1:0] r_s2_d0 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_pc[0] <= r_s1_d[1][1] * r_s1_d[2][2];
            r_s2_pc[1] <= r_s1_d[1][2] * r_s1_d[2][1];
            r_s2_pc[2] <= r_s1_d[1][2] * r_s1_d[2][0];
            r_s2_pc[3] <= r_s1_d[1][0] * r_s1_d[2][2];
            r_s2_pc[4] <= r_s1_d[1][0] * r_s1_d[2][1];
            r_s2_pc[5] <= r_s1_d[1][1] * r_s1_d[2][0];
            for (int k = 0; k < 3; k++) begin
                for (int v = 0; v < 3; v++) begin
                    r_s2_sq[v][k] <= r_s1_d[v][k] * r_s1_d[v][k];
                end
                r_s2_pr[0][k] <= r_s1_d[0][k] * r_s1_d[1][k];
                r_s2_pr[1][k] <= r_s1_d[0][k] * r_s1_d[2][k];
                r_s2_pr[2][k] <= r_s1_d[1][k] * r_s1_d[2][k];
                r_s2_d0[k]    <= r_s1_d[0][k];
            end
        end
    end

    // Cross product, squared lengths and pairwise dot products.
    logic signed [PW:0]     r_s3_c   [3];
    logic        [SW-1:0]   r_s3_s   [3];
    logic signed [DOTW-1:0] r_s3_dot [3];
    logic signed [OW-1:0]   r_s3_d0  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_c[0] <= (PW+1)'(r_s2_pc[0]) - (PW+1)'(r_s2_pc[1]);
            r_s3_c[1] <= (PW+1)'(r_s2_pc[2]) - (PW+1)'(r_s2_pc[3]);
            r_s3_c[2] <= (PW+1)'(r_s2_pc[4]) - (PW+1)'(r_s2_pc[5]);
            for (int v = 0; v < 3; v++) begin
                r_s3_s[v] <= $unsigned(r_s2_sq[v][0]) + $unsigned(r_s2_sq[v][1])
                           + $unsigned(r_s2_sq[v][2]);
                r_s3_dot[v] <= DOTW'(r_s2_pr[v][0]) + DOTW'(r_s2_pr[v][1])
                             + DOTW'(r_s2_pr[v][2]);
                r_s3_d0[v] <= r_s2_d0[v];
            end
        end
    end

    // Partial products of the triple product.
    logic signed [PW-1:0]   r_s4_pl  [3];
    logic signed [PW+1:0]   r_s4_ph  [3];
    logic        [SW-1:0]   r_s4_s   [3];
    logic signed [DOTW-1:0] r_s4_dot [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s4_pl[k]  <= r_s3_d0[k] * $signed({1'b0, r_s3_c[k][31:0]});
                r_s4_ph[k]  <= r_s3_d0[k] * $signed(r_s3_c[k][PW:32]);
                r_s4_s[k]   <= r_s3_s[k];
                r_s4_dot[k] <= r_s3_dot[k];
            end
        end
    end

    // Square root stages, one root bit per stage for all three lanes.
    t_sq r_q [LW+1];
    t_sq n_q0;

    always_comb begin
        logic signed [NW-1:0] nsum;
        nsum = '0;
        for (int k = 0; k < 3; k++) begin
            nsum = nsum + (NW'(r_s4_ph[k]) <<< 32) + NW'(r_s4_pl[k]);
        end
        n_q0.n = nsum;
        for (int v = 0; v < 3; v++) begin
            n_q0.s[v]    = r_s4_s[v];
            n_q0.root[v] = '0;
            n_q0.rem[v]  = '0;
            n_q0.dot[v]  = r_s4_dot[v];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q[0] <= n_q0;
        end
    end

    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        t_sq n_q;

        always_comb begin
            logic [RADW-1:0] rad;
            logic [REMW+1:0] rsh;
            logic [REMW+1:0] trial;
            n_q = r_q[k];
            for (int i = 0; i < 3; i++) begin
                rad   = RADW'({r_q[k].s[i], {LSH{1'b0}}});
                rsh   = {r_q[k].rem[i], rad[RADW-1-2*k -: 2]};
                trial = {1'b0, r_q[k].root[i], 2'b01};
                if (rsh >= trial) begin
                    n_q.rem[i]  = REMW'(rsh - trial);
                    n_q.root[i] = {r_q[k].root[i][LW-2:0], 1'b1};
                end else begin
                    n_q.rem[i]  = rsh[REMW-1:0];
                    n_q.root[i] = {r_q[k].root[i][LW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q[k+1] <= n_q;
            end
        end
    end

    // Denominator: product of lengths plus dot products weighted by lengths.
    logic [49:0]            r_e1_m [4];
    logic [58:0]            r_e1_ull [3];
    logic [58:0]            r_e1_ulh [3];
    logic signed [59:0]     r_e1_shl [3];
    logic signed [59:0]     r_e1_shh [3];
    logic [LW-1:0]          r_e1_lc;
    logic [RADW-1:0]        r_e2_p;
    logic [83:0]            r_e2_ta [3];
    logic signed [84:0]     r_e2_tb [3];
    logic [LW-1:0]          r_e2_lc;
    logic [49:0]            r_e3_pp [4][2];
    logic signed [119:0]    r_e3_t [3];
    logic [74:0]            r_e4_q [4];
    logic signed [121:0]    r_e4_t;
    logic [149:0]           r_e5_q;
    logic signed [121:0]    r_e5_t;
    logic signed [DW-1:0]   r_e6_d;
    logic signed [NW-1:0]   r_en [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1_m[0] <= r_q[LW].root[0][24:0]  * r_q[LW].root[1][24:0];
            r_e1_m[1] <= r_q[LW].root[0][24:0]  * r_q[LW].root[1][49:25];
            r_e1_m[2] <= r_q[LW].root[0][49:25] * r_q[LW].root[1][24:0];
            r_e1_m[3] <= r_q[LW].root[0][49:25] * r_q[LW].root[1][49:25];
            for (int j = 0; j < 3; j++) begin
                r_e1_ull[j] <= r_q[LW].dot[j][33:0] * r_q[LW].root[2-j][24:0];
                r_e1_ulh[j] <= r_q[LW].dot[j][33:0] * r_q[LW].root[2-j][49:25];
                r_e1_shl[j] <= $signed(r_q[LW].dot[j][DOTW-1:34])
                             * $signed({1'b0, r_q[LW].root[2-j][24:0]});
                r_e1_shh[j] <= $signed(r_q[LW].dot[j][DOTW-1:34])
                             * $signed({1'b0, r_q[LW].root[2-j][49:25]});
            end
            r_e1_lc <= r_q[LW].root[2];
            r_en[0] <= $signed(r_q[LW].n);

            r_e2_p <= RADW'(r_e1_m[0]) + (RADW'(r_e1_m[1]) << 25)
                    + (RADW'(r_e1_m[2]) << 25) + (RADW'(r_e1_m[3]) << 50);
            for (int j = 0; j < 3; j++) begin
                r_e2_ta[j] <= 84'(r_e1_ull[j]) + (84'(r_e1_ulh[j]) << 25);
                r_e2_tb[j] <= 85'(r_e1_shl[j]) + (85'(r_e1_shh[j]) <<< 25);
            end
            r_e2_lc <= r_e1_lc;
            r_en[1] <= r_en[0];

            for (int j = 0; j < 4; j++) begin
                r_e3_pp[j][0] <= r_e2_p[25*j +: 25] * r_e2_lc[24:0];
                r_e3_pp[j][1] <= r_e2_p[25*j +: 25] * r_e2_lc[49:25];
            end
            for (int j = 0; j < 3; j++) begin
                r_e3_t[j] <= 120'($signed({1'b0, r_e2_ta[j]})) + (120'(r_e2_tb[j]) <<< 34);
            end
            r_en[2] <= r_en[1];

            for (int j = 0; j < 4; j++) begin
                r_e4_q[j] <= 75'(r_e3_pp[j][0]) + (75'(r_e3_pp[j][1]) << 25);
            end
            r_e4_t  <= 122'(r_e3_t[0]) + 122'(r_e3_t[1]) + 122'(r_e3_t[2]);
            r_en[3] <= r_en[2];

            r_e5_q  <= 150'(r_e4_q[0]) + (150'(r_e4_q[1]) << 25)
                     + (150'(r_e4_q[2]) << 50) + (150'(r_e4_q[3]) << 75);
            r_e5_t  <= r_e4_t;
            r_en[4] <= r_en[3];

            r_e6_d  <= DW'($signed({1'b0, r_e5_q})) + (DW'(r_e5_t) <<< 32);
            r_en[5] <= r_en[4];
        end
    end

    // Normalization of both magnitudes to a common 60 bit window.
    logic [VW-1:0] r_f1_ny;
    logic [VW-1:0] r_f1_dy;
    logic [VW-1:0] r_f2_ny;
    logic [VW-1:0] r_f2_dy;
    logic [VW-1:0] r_f3_ny;
    logic [VW-1:0] r_f3_dy;
    logic [9:0]    r_f2_nz;
    logic [3:0]    r_f2_pos [10];
    logic [7:0]    r_f3_m;
    logic [74:0]   r_f4_nw;
    logic [74:0]   r_f4_dw;
    logic [3:0]    r_f4_lo;
    logic [3:0]    r_fzn;
    logic [3:0]    r_fzd;
    logic [NW-1:0] n_absn;
    logic [VW-1:0] n_absd;
    logic [159:0]  n_word;
    logic [9:0]    n_nz;
    logic [3:0]    n_pos [10];
    logic [7:0]    n_m;
    logic [VW+NORM-1:0] n_nsh;
    logic [VW+NORM-1:0] n_dsh;
    logic [74:0]   n_nf;
    logic [74:0]   n_df;
    t_cd           n_c0;

    always_comb begin
        n_absn = r_en[5][NW-1] ? NW'(-r_en[5]) : NW'(r_en[5]);
        n_absd = r_e6_d[DW-1] ? VW'(-r_e6_d) : VW'(r_e6_d);
        n_word = 160'(r_f1_ny | r_f1_dy);
        for (int c = 0; c < 10; c++) begin
            n_nz[c]  = |n_word[16*c +: 16];
            n_pos[c] = '0;
            for (int b = 0; b < 16; b++) begin
                if (n_word[16*c+b]) begin
                    n_pos[c] = 4'(b);
                end
            end
        end
        n_m = '0;
        for (int c = 0; c < 10; c++) begin
            if (r_f2_nz[c]) begin
                n_m = 8'(c * 16) + 8'(r_f2_pos[c]) + 8'd1;
            end
        end
        n_nsh = {r_f3_ny, {NORM{1'b0}}} >> {r_f3_m[7:4], 4'b0000};
        n_dsh = {r_f3_dy, {NORM{1'b0}}} >> {r_f3_m[7:4], 4'b0000};
        n_nf  = r_f4_nw >> r_f4_lo;
        n_df  = r_f4_dw >> r_f4_lo;
        n_c0.x  = XW'(n_df[NORM-1:0]);
        n_c0.y  = XW'(n_nf[NORM-1:0]);
        n_c0.z  = '0;
        n_c0.zn = r_fzn[3];
        n_c0.zd = r_fzd[3];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_ny  <= VW'(n_absn) << NSH;
            r_f1_dy  <= n_absd;
            r_fzn[0] <= (r_en[5] == '0);
            r_fzd[0] <= (r_e6_d == '0);
            r_f2_ny  <= r_f1_ny;
            r_f2_dy  <= r_f1_dy;
            r_f2_nz  <= n_nz;
            for (int c = 0; c < 10; c++) begin
                r_f2_pos[c] <= n_pos[c];
            end
            r_f3_ny  <= r_f2_ny;
            r_f3_dy  <= r_f2_dy;
            r_f3_m   <= n_m;
            r_f4_nw  <= n_nsh[74:0];
            r_f4_dw  <= n_dsh[74:0];
            r_f4_lo  <= r_f3_m[3:0];
            for (int k = 1; k < 4; k++) begin
                r_fzn[k] <= r_fzn[k-1];
                r_fzd[k] <= r_fzd[k-1];
            end
        end
    end

    // Arctangent by vectoring rotations, one rotation per stage.
    t_cd r_c [CS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[0] <= n_c0;
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        t_cd n_c;

        always_comb begin
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            logic signed [ZW-1:0] ang;
            xs  = $signed(r_c[i].x) >>> i;
            ys  = $signed(r_c[i].y) >>> i;
            ang = $signed(ZW'(ATAN_TAB[i]));
            n_c = r_c[i];
            if (!r_c[i].y[XW-1]) begin
                n_c.x = $signed(r_c[i].x) + ys;
                n_c.y = $signed(r_c[i].y) - xs;
                n_c.z = $signed(r_c[i].z) + ang;
            end else begin
                n_c.x = $signed(r_c[i].x) - ys;
                n_c.y = $signed(r_c[i].y) + xs;
                n_c.z = $signed(r_c[i].z) - ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c[i+1] <= n_c;
            end
        end
    end

    always_comb begin
        logic signed [ZW:0] z2;
        z2 = {r_c[CS].z, 1'b0};
        if (r_c[CS].zn) begin
            n_res = '0;
        end else if (r_c[CS].zd) begin
            n_res = PI_Q30;
        end else if (r_c[CS].z[ZW-1]) begin
            n_res = '0;
        end else if (z2 > $signed({3'b000, PI_Q30})) begin
            n_res = PI_Q30;
        end else begin
            n_res = z2[31:0];
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (!r_ov || i_m_axis_tready) begin
            r_ov   <= r_sk_v || r_vld[DEPTH-1];
            r_sk_v <= 1'b0;
        end else if (en && r_vld[DEPTH-1]) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_axis_tready) begin
            r_od <= r_sk_v ? r_sk_d : n_res;
        end else if (en && r_vld[DEPTH-1]) begin
            r_sk_d <= n_res;
        end
    end

    a_skid_behind_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_ov)
        else $error("skid register holds a result while the output is empty");

    a_skid_drains_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && i_m_axis_tready) |=> (r_ov && r_od == $past(r_sk_d)))
        else $error("buffered result was not presented next");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata <= PI_Q30))
        else $error("solid angle above pi");

endmodule
